[hw/rtl/dsor_pkg.sv]
// Shared types and constants for the settle order recorder
`default_nettype none
package dsor_pkg;
  localparam int unsigned NodeW   = 6;
  localparam int unsigned WeightW = 32;
  localparam int unsigned DistW   = 38;
  localparam int unsigned NcfgW   = 7;
  localparam int unsigned MaskW   = 64;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [DistW-1:0] a;
    logic [DistW-1:0] b;
  } alu_req_t;
endpackage
`default_nettype wire

[hw/rtl/dsor_ram.sv]
// Single write port, single registered read port memory
`default_nettype none
module dsor_ram #(
  parameter int unsigned Width = 44,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/dsor_alu.sv]
// Shared distance adder/subtractor and heap key comparator
`default_nettype none
module dsor_alu #(
  parameter int unsigned NodeIdxW = 6
) (
  input  wire dsor_pkg::alu_req_t          req_i,
  output logic [dsor_pkg::DistW-1:0]       res_o,
  input  wire logic [dsor_pkg::DistW-1:0]  cand_dist_i,
  input  wire logic [NodeIdxW-1:0]         cand_node_i,
  input  wire logic [dsor_pkg::DistW-1:0]  best_dist_i,
  input  wire logic [NodeIdxW-1:0]         best_node_i,
  output logic                             better_o
);
  import dsor_pkg::*;

  always_comb begin
    unique case (req_i.op)
      ALU_ADD: res_o = req_i.a + req_i.b;
      ALU_SUB: res_o = req_i.a - req_i.b;
      default: res_o = req_i.a;
    endcase
  end

  assign better_o = (cand_dist_i < best_dist_i) ||
                    ((cand_dist_i == best_dist_i) && (cand_node_i > best_node_i));
endmodule
`default_nettype wire

[hw/rtl/dijkstra_settle_order_recorder.sv]
// Top level: edge loader and shortest-path settle sequencer
// Loading: an item without last_edge is taken while idle, and busy stays low.
// Search: an expansion reads every stored edge and pushes the far end of each edge
// touching the settled node; a selection scans all heap entries, then pops and checks.
// Throughput: one graph at a time; busy holds until the summary word is issued.
// Reset is asynchronous; memories are not cleared, fill counts guard them.
`default_nettype none
module dijkstra_settle_order_recorder #(
  parameter int unsigned MAX_NODES  = 64,
  parameter int unsigned MAX_EDGES  = 256,
  parameter int unsigned HEAP_DEPTH = 512
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           edge_present_i,
  input  wire logic [dsor_pkg::NodeW-1:0]     edge_from_i,
  input  wire logic [dsor_pkg::NodeW-1:0]     edge_to_i,
  input  wire logic [dsor_pkg::WeightW-1:0]   edge_weight_i,
  input  wire logic                           last_edge_i,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dsor_pkg::NcfgW-1:0]     cfg_data,
  output logic                                result_strobe,
  output logic                                record_kind_o,
  output logic [dsor_pkg::MaskW-1:0]          visited_mask_o,
  output logic [dsor_pkg::DistW-1:0]          step_gain_o,
  output logic [dsor_pkg::DistW-1:0]          total_distance_o,
  output logic                                target_reached_o,
  output logic                                last_result_o
);
  import dsor_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_NODES);
  localparam int unsigned EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EFW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned HAW  = $clog2(HEAP_DEPTH);
  localparam int unsigned HFW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned EDW  = 2 * NodeW + WeightW;
  localparam int unsigned HDW  = DistW + NW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EX_RD, ST_EX_ADD, ST_EX_PA, ST_EX_PB, ST_SEL,
    ST_SC_RD, ST_SC_CMP, ST_POP_RD, ST_POP_WR, ST_CHECK, ST_SUM
  } state_e;

  state_e               state_q;
  logic [NcfgW-1:0]     ncfg_q;
  logic [NcfgW-1:0]     nodes_q;
  logic [NW-1:0]        tgt_q;
  logic [EFW-1:0]       etot_q;
  logic [EFW-1:0]       eidx_q;
  logic [MAX_NODES-1:0] mask_q;
  logic [HFW-1:0]       hfill_q;
  logic [HFW-1:0]       hidx_q;
  logic [DistW-1:0]     cur_q;
  logic [NW-1:0]        u_q;
  logic [DistW-1:0]     base_q;
  logic [DistW-1:0]     d_q;
  logic [DistW-1:0]     bdist_q;
  logic [NW-1:0]        bnode_q;
  logic [HAW-1:0]       bidx_q;

  logic                 in_acc;
  logic [NcfgW-1:0]     nodes_c;
  logic [NcfgW-1:0]     tgt_c;
  logic [HFW-1:0]       hlast_c;

  logic                 e_we;
  logic [EDW-1:0]       e_rdata;
  logic [NodeW-1:0]     ea;
  logic [NodeW-1:0]     eb;
  logic [WeightW-1:0]   ew;

  logic                 h_we;
  logic [HAW-1:0]       h_waddr;
  logic [HDW-1:0]       h_wdata;
  logic [HAW-1:0]       h_raddr;
  logic [HDW-1:0]       h_rdata;
  logic [DistW-1:0]     h_rdist;
  logic [NW-1:0]        h_rnode;

  logic                 heap_full;
  logic                 push_a;
  logic                 push_b;

  alu_req_t             alu_req;
  logic [DistW-1:0]     alu_res;
  logic                 better;

  assign busy      = (state_q != ST_IDLE);
  assign cfg_ready = !busy;
  assign in_acc    = start && !busy;

  assign nodes_c = (ncfg_q == '0) ? NcfgW'(1) :
                   (ncfg_q > NcfgW'(MAX_NODES)) ? NcfgW'(MAX_NODES) : ncfg_q;
  assign tgt_c   = nodes_c - NcfgW'(1);
  assign hlast_c = hfill_q - HFW'(1);

  assign {ea, eb, ew}       = e_rdata;
  assign {h_rdist, h_rnode} = h_rdata;

  assign heap_full = (hfill_q == HFW'(HEAP_DEPTH));
  assign push_a = (ea == NodeW'(u_q)) && ({1'b0, eb} < nodes_q) && !heap_full;
  assign push_b = (eb == NodeW'(u_q)) && ({1'b0, ea} < nodes_q) && !heap_full;

  assign e_we = in_acc && edge_present_i && (etot_q < EFW'(MAX_EDGES));

  dsor_ram #(.Width(EDW), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (etot_q[EAW-1:0]),
    .wdata_i ({edge_from_i, edge_to_i, edge_weight_i}),
    .raddr_i (eidx_q[EAW-1:0]),
    .rdata_o (e_rdata)
  );

  always_comb begin
    h_we    = 1'b0;
    h_waddr = hfill_q[HAW-1:0];
    h_wdata = {d_q, eb[NW-1:0]};
    h_raddr = hidx_q[HAW-1:0];
    unique case (state_q)
      ST_EX_PA:  h_we = push_a;
      ST_EX_PB: begin
        h_we    = push_b;
        h_wdata = {d_q, ea[NW-1:0]};
      end
      ST_POP_RD: h_raddr = hlast_c[HAW-1:0];
      ST_POP_WR: begin
        h_we    = 1'b1;
        h_waddr = bidx_q;
        h_wdata = h_rdata;
      end
      default: ;
    endcase
  end

  dsor_ram #(.Width(HDW), .Depth(HEAP_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = base_q;
    alu_req.b  = DistW'(ew);
    if (state_q == ST_CHECK) begin
      alu_req.op = ALU_SUB;
      alu_req.a  = bdist_q;
      alu_req.b  = cur_q;
    end
  end

  dsor_alu #(.NodeIdxW(NW)) u_alu (
    .req_i       (alu_req),
    .res_o       (alu_res),
    .cand_dist_i (h_rdist),
    .cand_node_i (h_rnode),
    .best_dist_i (bdist_q),
    .best_node_i (bnode_q),
    .better_o    (better)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      ncfg_q           <= NcfgW'(64);
      nodes_q          <= '0;
      tgt_q            <= '0;
      etot_q           <= '0;
      eidx_q           <= '0;
      mask_q           <= MAX_NODES'(1);
      hfill_q          <= '0;
      hidx_q           <= '0;
      cur_q            <= '0;
      u_q              <= '0;
      base_q           <= '0;
      d_q              <= '0;
      bdist_q          <= '0;
      bnode_q          <= '0;
      bidx_q           <= '0;
      result_strobe    <= 1'b0;
      record_kind_o    <= 1'b0;
      visited_mask_o   <= '0;
      step_gain_o      <= '0;
      total_distance_o <= '0;
      target_reached_o <= 1'b0;
      last_result_o    <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        ncfg_q <= cfg_data;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (e_we) begin
              etot_q <= etot_q + EFW'(1);
            end
            if (last_edge_i) begin
              nodes_q <= nodes_c;
              tgt_q   <= tgt_c[NW-1:0];
              mask_q  <= MAX_NODES'(1);
              cur_q   <= '0;
              hfill_q <= '0;
              u_q     <= '0;
              base_q  <= '0;
              eidx_q  <= '0;
              state_q <= ST_EX_RD;
            end
          end
        end
        ST_EX_RD: begin
          state_q <= (eidx_q == etot_q) ? ST_SEL : ST_EX_ADD;
        end
        ST_EX_ADD: begin
          d_q     <= alu_res;
          state_q <= ST_EX_PA;
        end
        ST_EX_PA: begin
          if (push_a) begin
            hfill_q <= hfill_q + HFW'(1);
          end
          state_q <= ST_EX_PB;
        end
        ST_EX_PB: begin
          if (push_b) begin
            hfill_q <= hfill_q + HFW'(1);
          end
          eidx_q  <= eidx_q + EFW'(1);
          state_q <= ST_EX_RD;
        end
        ST_SEL: begin
          hidx_q <= '0;
          if (hfill_q == '0 || mask_q[tgt_q]) begin
            state_q <= ST_SUM;
          end else begin
            state_q <= ST_SC_RD;
          end
        end
        ST_SC_RD: state_q <= ST_SC_CMP;
        ST_SC_CMP: begin
          if (hidx_q == '0 || better) begin
            bdist_q <= h_rdist;
            bnode_q <= h_rnode;
            bidx_q  <= hidx_q[HAW-1:0];
          end
          hidx_q  <= hidx_q + HFW'(1);
          state_q <= (hidx_q + HFW'(1) == hfill_q) ? ST_POP_RD : ST_SC_RD;
        end
        ST_POP_RD: state_q <= ST_POP_WR;
        ST_POP_WR: begin
          hfill_q <= hlast_c;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (mask_q[bnode_q]) begin
            state_q <= ST_SEL;
          end else begin
            result_strobe    <= 1'b1;
            record_kind_o    <= 1'b0;
            visited_mask_o   <= MaskW'(mask_q);
            step_gain_o      <= alu_res;
            total_distance_o <= bdist_q;
            target_reached_o <= 1'b0;
            last_result_o    <= 1'b0;
            mask_q[bnode_q]  <= 1'b1;
            cur_q            <= bdist_q;
            u_q              <= bnode_q;
            base_q           <= bdist_q;
            eidx_q           <= '0;
            state_q          <= ST_EX_RD;
          end
        end
        ST_SUM: begin
          result_strobe    <= 1'b1;
          record_kind_o    <= 1'b1;
          visited_mask_o   <= MaskW'(mask_q);
          step_gain_o      <= '0;
          total_distance_o <= mask_q[tgt_q] ? cur_q : '0;
          target_reached_o <= mask_q[tgt_q];
          last_result_o    <= 1'b1;
          etot_q           <= '0;
          mask_q           <= MAX_NODES'(1);
          hfill_q          <= '0;
          cur_q            <= '0;
          state_q          <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe && last_result_o |-> !busy)
    else $error("summary word not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe && !record_kind_o |-> busy)
    else $error("settle word while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hfill_q <= HFW'(HEAP_DEPTH))
    else $error("heap fill beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> mask_q[0])
    else $error("source node not settled");

endmodule
`default_nettype wire
